@@ rtl/sorted_priority_queue_core_defines.svh @@
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                             kind;
    logic [VALUE_WIDTH-1:0]           item_value;
    logic signed [PRIORITY_WIDTH-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] removed_value;
    logic [VALUE_WIDTH-1:0] head_value;
    logic [COUNT_WIDTH-1:0] entry_count;
    logic                   is_empty;
    logic [1:0]             status;
  } spq_out_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]           value;
    logic signed [PRIORITY_WIDTH-1:0] prio;
  } spq_entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_op_t;

endpackage

@@ rtl/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_op_t    op,
  input  logic       occupied,
  input  logic       left_keep,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       keep,
  output spq_entry_t entry_q,
  output spq_entry_t entry_nxt
);

  spq_entry_t entry_r;

  // held entry stays put when it sorts at or ahead of the new one
  assign keep = occupied && (entry_r.prio <= op.entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (op.enq) begin
      if (!keep) begin
        entry_nxt = left_keep ? op.entry : left_entry;
      end
    end else if (op.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// sorted priority queue, QUEUE_DEPTH entries kept in ascending signed priority
// input channel: in_valid / in_stall / in_data, one beat is one operation,
//   kind 0 enqueues (item_value, item_priority), kind 1 dequeues the head
// result channel: out_valid / out_stall / out_data, exactly one beat per
//   input beat, in order: removed value, head after the step, count, empty
//   flag and status (ok, dequeue on empty, enqueue on full dropped)
// the result beat is registered and shows in the cycle after its input beat is taken
// throughput: one beat per cycle while no result waits under out_stall; every cell
//   compares its priority with the new one in parallel and shifts toward its neighbor in the same cycle
// equal priorities keep arrival order: a held entry stays in place when its
//   priority is at or below the new one
// reset: entry count goes to zero, no result is pending; cell contents are
//   not cleared since cells at or beyond the count are never read
// stall: while a result beat waits under out_stall, in_stall is raised and
//   no new beat is taken; the waiting beat holds steady
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_data
);

`include "sorted_priority_queue_core_defines.svh"

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  spq_out_t               out_data_r, out_data_nxt;

  logic       accept;
  logic       is_full, is_zero;
  logic       enq_ok, deq_ok;
  spq_op_t    op;

  logic       [QUEUE_DEPTH-1:0] keep;
  logic       [QUEUE_DEPTH-1:0] occupied;
  spq_entry_t                   entry_q   [QUEUE_DEPTH];
  spq_entry_t                   entry_nxt [QUEUE_DEPTH];

  // the output register is the only thing that can hold off the input
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_full = (count_r == COUNT_WIDTH'(QUEUE_DEPTH));
  assign is_zero = (count_r == '0);
  assign enq_ok  = accept && (in_data.kind == KIND_ENQ) && !is_full;
  assign deq_ok  = accept && (in_data.kind == KIND_DEQ) && !is_zero;

  // rejected operations leave the cells untouched
  assign op.enq         = enq_ok;
  assign op.deq         = deq_ok;
  assign op.entry.value = in_data.item_value;
  assign op.entry.prio  = in_data.item_priority;

  // row of cells, cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (count_r > COUNT_WIDTH'(i));

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .occupied   (occupied[i]),
        .left_keep  (1'b1),
        .left_entry (op.entry),
        .right_entry(entry_q[i+1]),
        .keep       (keep[i]),
        .entry_q    (entry_q[i]),
        .entry_nxt  (entry_nxt[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      // nothing beyond the tail; it refills with its own stale content
      spq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .occupied   (occupied[i]),
        .left_keep  (keep[i-1]),
        .left_entry (entry_q[i-1]),
        .right_entry(entry_q[i]),
        .keep       (keep[i]),
        .entry_q    (entry_q[i]),
        .entry_nxt  (entry_nxt[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .occupied   (occupied[i]),
        .left_keep  (keep[i-1]),
        .left_entry (entry_q[i-1]),
        .right_entry(entry_q[i+1]),
        .keep       (keep[i]),
        .entry_q    (entry_q[i]),
        .entry_nxt  (entry_nxt[i])
      );
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + COUNT_WIDTH'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - COUNT_WIDTH'(1);
    end
  end

  // result beat: removed value from the head cell before the step, head value and count after it
  always_comb begin
    out_data_nxt.removed_value = deq_ok ? entry_q[0].value : '0;
    out_data_nxt.head_value    = (count_nxt != '0) ? entry_nxt[0].value : '0;
    out_data_nxt.entry_count   = count_nxt;
    out_data_nxt.is_empty      = (count_nxt == '0);
    out_data_nxt.status        = ST_OK;
    if (in_data.kind == KIND_DEQ && is_zero) begin
      out_data_nxt.status = ST_EMPTY;
    end else if (in_data.kind == KIND_ENQ && is_full) begin
      out_data_nxt.status = ST_FULL;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count never runs past the number of cells, reset edges excused
  `SPQ_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= COUNT_WIDTH'(QUEUE_DEPTH)), "count over depth")
  // entry count only moves on an accepted beat
  `SPQ_ASSERT(a_count_hold, !accept |=> $stable(count_r), "count moved without a beat")
  // an enqueue is carried out only while the queue is not full
  `SPQ_ASSERT(a_full_drop, enq_ok |-> !is_full, "enqueue into full queue")
  // the reported count always matches the queue after the step
  `SPQ_ASSERT(a_count_report, accept |=> out_data.entry_count == count_r, "count mismatch")

endmodule

@@ verif/tb_sorted_priority_queue_core.sv @@
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  // beats left in the queue when idling on both sides stops
  localparam int TAIL_BEATS = 50;
  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_BEATS = 400;

  // one pending beat for the driver, with an optional drain request
  typedef struct {
    spq_in_t beat;
    bit      wait_drain;
  } op_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  spq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_data;

  op_req_t  pending_ops[$];
  spq_out_t expected_results[$];

  // shadow copy of the sorted queue, index 0 is the head
  logic [VALUE_WIDTH-1:0]           held_values [QUEUE_DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] held_prios [QUEUE_DEPTH];
  int held_count = 0;

  int beats_sent = 0;
  int beats_checked = 0;
  int mismatch_count = 0;
  int full_drops = 0;
  int empty_deqs = 0;
  int in_stall_cycles = 0;
  int peak_count = 0;

  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_idx = 0;
  int hold_points[2] = '{100, 280};

  sorted_priority_queue_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // apply one operation to the shadow queue and build the result beat
  function automatic spq_out_t apply_queue_op(spq_in_t op);
    spq_out_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (op.kind == KIND_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry at or below its priority
        pos = 0;
        while (pos < held_count && held_prios[pos] <= op.item_priority) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_values[i] = held_values[i-1];
          held_prios[i]  = held_prios[i-1];
        end
        held_values[pos] = op.item_value;
        held_prios[pos]  = op.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_value = held_values[0];
        for (int i = 1; i < held_count; i++) begin
          held_values[i-1] = held_values[i];
          held_prios[i-1]  = held_prios[i];
        end
        held_count--;
      end
    end
    r.head_value  = (held_count > 0) ? held_values[0] : '0;
    r.entry_count = held_count[COUNT_WIDTH-1:0];
    r.is_empty    = (held_count == 0);
    return r;
  endfunction

  task automatic queue_beat(logic kind, logic [VALUE_WIDTH-1:0] value,
                            logic signed [PRIORITY_WIDTH-1:0] prio, bit drain);
    op_req_t req;
    req.beat.kind          = kind;
    req.beat.item_value    = value;
    req.beat.item_priority = prio;
    req.wait_drain         = drain;
    pending_ops.push_back(req);
  endtask

  // driver: one beat offered at a time, held steady until taken
  always @(posedge clk) begin
    op_req_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // beat taken at this edge, predict its result now
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_queue_op(in_data));
        beats_sent++;
        if (held_count > peak_count) peak_count = held_count;
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0].wait_drain && expected_results.size() > 0) begin
          // pause until every outstanding result is back
          in_valid <= 1'b0;
        end else if (pending_ops.size() > TAIL_BEATS && $urandom_range(0, 99) < 10) begin
          send_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else begin
          next_req = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_req.beat;
        end
      end
    end
  end

  // monitor: checks each result beat and drives out_stall
  always @(posedge clk) begin
    spq_out_t exp_beat;
    bit bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result beat: %p", out_data);
          mismatch_count++;
        end else begin
          exp_beat = expected_results.pop_front();
          bad = (out_data.removed_value !== exp_beat.removed_value) ||
                (out_data.head_value    !== exp_beat.head_value) ||
                (out_data.entry_count   !== exp_beat.entry_count) ||
                (out_data.is_empty      !== exp_beat.is_empty) ||
                (out_data.status        !== exp_beat.status);
          if (bad) begin
            if (mismatch_count < 10)
              $display("mismatch at beat %0d: expected %p, got %p",
                       beats_checked, exp_beat, out_data);
            mismatch_count++;
          end
          if (exp_beat.status == ST_FULL) full_drops++;
          if (exp_beat.status == ST_EMPTY) empty_deqs++;
          beats_checked++;
        end
      end
      // long hold-off lets the sender back up against in_stall
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_idx < 2 && beats_sent >= hold_points[hold_idx]) begin
        hold_left = HOLD_CYCLES - 1;
        hold_idx++;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (pending_ops.size() > TAIL_BEATS && $urandom_range(0, 99) < 10) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic signed [PRIORITY_WIDTH-1:0] dir_prios[16];
    logic signed [PRIORITY_WIDTH-1:0] p;
    logic [VALUE_WIDTH-1:0] v;
    logic k;
    int mode;
    bit enq_heavy;

    // directed: dequeue on empty first
    queue_beat(KIND_DEQ, 32'hFFFF_FFFF, 16'sh7FFF, 1'b0);
    // fill to full with extremes and ties, Q8.8 steps included
    dir_prios = '{16'sh0000, 16'sh0000, -16'sd32768, 16'sh7FFF,
                  -16'sd1, 16'sd1, 16'sh0100, -16'sh0100,
                  16'sh0000, 16'sh7FFF, -16'sd32768, 16'sh0080,
                  -16'sh0080, 16'sd5, -16'sd5, 16'sh0100};
    for (int i = 0; i < 16; i++) begin
      v = (i == 2) ? 32'h0 : (i == 3) ? 32'hFFFF_FFFF : 32'h100 + i;
      queue_beat(KIND_ENQ, v, dir_prios[i], 1'b0);
    end
    // enqueue on full is dropped even with the lowest priority
    queue_beat(KIND_ENQ, 32'hDEAD_BEEF, -16'sd32768, 1'b0);
    for (int i = 0; i < 4; i++) queue_beat(KIND_DEQ, 32'h0, 16'sh0, 1'b0);
    // insertion between equal priorities after dequeues
    queue_beat(KIND_ENQ, 32'h5A5A_A5A5, 16'sh0000, 1'b0);

    // random: alternating enqueue-heavy and dequeue-heavy stretches
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      enq_heavy = ((i / 40) % 2) == 0;
      k = ($urandom_range(0, 99) < 75) ? (enq_heavy ? KIND_ENQ : KIND_DEQ)
                                       : (enq_heavy ? KIND_DEQ : KIND_ENQ);
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          p = 16'($urandom_range(0, 6));
          p = p - 16'sd3;
        end
        1: begin
          case ($urandom_range(0, 3))
            0: p = -16'sd32768;
            1: p = 16'sh7FFF;
            2: p = -16'sd1;
            default: p = 16'sh0;
          endcase
        end
        default: p = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: v = 32'h0;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      queue_beat(k, v, p, (i == 0) || (i == 200));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the sender to run dry and every result to come back
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d result beats: %0d full drops, %0d empty dequeues",
             beats_checked, full_drops, empty_deqs);
    $display("peak occupancy %0d, %0d cycles of input held off, %0d mismatches",
             peak_count, in_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
